// ----- rtl/core/char_lcd_command_sequencer_defines.svh -----
// Assertion macros used by the checker file of the LCD command sequencer.
// No dependencies; include by bare file name.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_DEFINES_SVH

// Check a property at every clock edge, reset included.
`define CLCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property only outside reset.
`define CLCD_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- rtl/core/clcd_pkg.sv -----
// Shared types, constants and the microcode table of the LCD command sequencer.
// No dependencies.
`timescale 1ns / 1ps

package clcd_pkg;

  // Field widths
  localparam int KIND_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int COL_W   = 6;
  localparam int NUM_W   = 31;
  localparam int ROWS_W  = 64;
  localparam int MS_W    = 8;
  localparam int WAIT_W  = 9;
  localparam int DIGIT_W = 4;

  // Glyph geometry
  localparam int GLYPH_ROWS = 8;
  localparam int ROW_SEL_W  = $clog2(GLYPH_ROWS);

  // Default digit capacity of the number conversion
  localparam int MAX_DIGITS_DEF = 10;

  // Divide by ten: q = (n * RECIP) >> DIV_SHIFT, exact for 32-bit n
  localparam logic [31:0] RECIP = 32'hCCCC_CCCD;
  localparam int DIV_SHIFT = 35;
  localparam int PROD_W    = NUM_W + 32;
  localparam int Q_W       = PROD_W - DIV_SHIFT;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INIT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CMD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CHAR   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CURSOR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STORE  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SHOW   = 3'd6;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_STROBE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POWERUP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_GAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_GAP = 3'd4;

  // LCD bytes
  localparam logic [BYTE_W-1:0] LCD_FUNC_SET  = 8'b0011_1000;
  localparam logic [BYTE_W-1:0] LCD_DISP_ON   = 8'b0000_1111;
  localparam logic [BYTE_W-1:0] LCD_CLEAR     = 8'b0000_0001;
  localparam logic [BYTE_W-1:0] LCD_ENTRY     = 8'b0000_0110;
  localparam logic [BYTE_W-1:0] LCD_DDRAM     = 8'h80;
  localparam logic [BYTE_W-1:0] LCD_CGRAM     = 8'b0100_0000;
  localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'h30;

  typedef struct packed {
    logic [MS_W-1:0] strobe_ms;
    logic [MS_W-1:0] hold_ms;
    logic [MS_W-1:0] powerup_ms;
    logic [MS_W-1:0] init_gap_ms;
    logic [MS_W-1:0] clear_gap_ms;
  } cfg_t;

  // Microcode fields
  typedef enum logic [2:0] {
    OP_DISPATCH, OP_NOP, OP_EMIT, OP_MUL, OP_FIX, OP_RD
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER, C_DIV_MORE, C_CNT_NZ, C_ROW_MORE, C_GLYPH_BAD
  } cond_t;

  typedef enum logic [2:0] {
    S_IMM, S_BYTE, S_CURSOR, S_DIGIT, S_GADDR, S_ROW, S_GIDX
  } src_t;

  typedef enum logic {W_ZERO, W_POWERUP} wb_t;

  typedef enum logic [1:0] {A_HOLD, A_INIT, A_CLEAR} wa_t;

  typedef enum logic [1:0] {L_NO, L_YES, L_CNT_ZERO} lst_t;

  localparam int PC_W = 5;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic             fin;     // return to dispatch when the jump is not taken
    src_t             src;
    logic             rs;
    wb_t              wb;
    wa_t              wa;
    lst_t             lst;
    logic             cnt_up;
    logic [BYTE_W-1:0] imm;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic   take;
    logic   go;
    uword_t uw;
  } seq_ctl_t;

  typedef struct packed {
    logic div_more;
    logic cnt_nz;
    logic row_more;
    logic glyph_bad;
    logic slot_free;
  } dp_stat_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] PC_INIT0    = 5'd1;
  localparam logic [PC_W-1:0] PC_INIT1    = 5'd2;
  localparam logic [PC_W-1:0] PC_INIT2    = 5'd3;
  localparam logic [PC_W-1:0] PC_INIT3    = 5'd4;
  localparam logic [PC_W-1:0] PC_CMD      = 5'd5;
  localparam logic [PC_W-1:0] PC_CHR      = 5'd6;
  localparam logic [PC_W-1:0] PC_CUR      = 5'd7;
  localparam logic [PC_W-1:0] PC_NUM_MUL  = 5'd8;
  localparam logic [PC_W-1:0] PC_NUM_FIX  = 5'd9;
  localparam logic [PC_W-1:0] PC_NUM_RD   = 5'd10;
  localparam logic [PC_W-1:0] PC_NUM_EMIT = 5'd11;
  localparam logic [PC_W-1:0] PC_GLY_CMD  = 5'd12;
  localparam logic [PC_W-1:0] PC_GLY_ROW  = 5'd13;
  localparam logic [PC_W-1:0] PC_GLY_END  = 5'd14;
  localparam logic [PC_W-1:0] PC_SHOW_CHK = 5'd15;
  localparam logic [PC_W-1:0] PC_SHOW     = 5'd16;

  function automatic uword_t mk(op_t op, cond_t cond, logic fin, src_t src, logic rs,
                                wb_t wb, wa_t wa, lst_t lst, logic cnt_up,
                                logic [BYTE_W-1:0] imm, logic [PC_W-1:0] target);
    mk = '{op, cond, fin, src, rs, wb, wa, lst, cnt_up, imm, target};
  endfunction

  // Control store
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    w = mk(OP_NOP, C_NEVER, 1'b1, S_IMM, 1'b0, W_ZERO, A_HOLD, L_NO, 1'b0, '0, PC_IDLE);
    unique case (pc)
      PC_IDLE:     w = mk(OP_DISPATCH, C_NEVER, 1'b0, S_IMM, 1'b0, W_ZERO, A_HOLD,
                          L_NO, 1'b0, '0, PC_IDLE);
      PC_INIT0:    w = mk(OP_EMIT, C_NEVER, 1'b0, S_IMM, 1'b0, W_POWERUP, A_INIT,
                          L_NO, 1'b0, LCD_FUNC_SET, PC_IDLE);
      PC_INIT1:    w = mk(OP_EMIT, C_NEVER, 1'b0, S_IMM, 1'b0, W_ZERO, A_INIT,
                          L_NO, 1'b0, LCD_DISP_ON, PC_IDLE);
      PC_INIT2:    w = mk(OP_EMIT, C_NEVER, 1'b0, S_IMM, 1'b0, W_ZERO, A_CLEAR,
                          L_NO, 1'b0, LCD_CLEAR, PC_IDLE);
      PC_INIT3:    w = mk(OP_EMIT, C_NEVER, 1'b1, S_IMM, 1'b0, W_ZERO, A_INIT,
                          L_YES, 1'b0, LCD_ENTRY, PC_IDLE);
      PC_CMD:      w = mk(OP_EMIT, C_NEVER, 1'b1, S_BYTE, 1'b0, W_ZERO, A_HOLD,
                          L_YES, 1'b0, '0, PC_IDLE);
      PC_CHR:      w = mk(OP_EMIT, C_NEVER, 1'b1, S_BYTE, 1'b1, W_ZERO, A_HOLD,
                          L_YES, 1'b0, '0, PC_IDLE);
      PC_CUR:      w = mk(OP_EMIT, C_NEVER, 1'b1, S_CURSOR, 1'b0, W_ZERO, A_HOLD,
                          L_YES, 1'b0, '0, PC_IDLE);
      PC_NUM_MUL:  w = mk(OP_MUL, C_NEVER, 1'b0, S_IMM, 1'b0, W_ZERO, A_HOLD,
                          L_NO, 1'b0, '0, PC_IDLE);
      PC_NUM_FIX:  w = mk(OP_FIX, C_DIV_MORE, 1'b0, S_IMM, 1'b0, W_ZERO, A_HOLD,
                          L_NO, 1'b0, '0, PC_NUM_MUL);
      PC_NUM_RD:   w = mk(OP_RD, C_NEVER, 1'b0, S_IMM, 1'b0, W_ZERO, A_HOLD,
                          L_NO, 1'b0, '0, PC_IDLE);
      PC_NUM_EMIT: w = mk(OP_EMIT, C_CNT_NZ, 1'b1, S_DIGIT, 1'b1, W_ZERO, A_HOLD,
                          L_CNT_ZERO, 1'b0, '0, PC_NUM_RD);
      PC_GLY_CMD:  w = mk(OP_EMIT, C_NEVER, 1'b0, S_GADDR, 1'b0, W_ZERO, A_HOLD,
                          L_NO, 1'b0, '0, PC_IDLE);
      PC_GLY_ROW:  w = mk(OP_EMIT, C_ROW_MORE, 1'b0, S_ROW, 1'b1, W_ZERO, A_HOLD,
                          L_NO, 1'b1, '0, PC_GLY_ROW);
      PC_GLY_END:  w = mk(OP_EMIT, C_NEVER, 1'b1, S_IMM, 1'b0, W_ZERO, A_HOLD,
                          L_YES, 1'b0, LCD_DDRAM, PC_IDLE);
      PC_SHOW_CHK: w = mk(OP_NOP, C_GLYPH_BAD, 1'b0, S_IMM, 1'b0, W_ZERO, A_HOLD,
                          L_NO, 1'b0, '0, PC_IDLE);
      PC_SHOW:     w = mk(OP_EMIT, C_NEVER, 1'b1, S_GIDX, 1'b1, W_ZERO, A_HOLD,
                          L_YES, 1'b0, '0, PC_IDLE);
      default:     w = mk(OP_NOP, C_NEVER, 1'b1, S_IMM, 1'b0, W_ZERO, A_HOLD,
                          L_NO, 1'b0, '0, PC_IDLE);
    endcase
    ucode = w;
  endfunction

  // Program entry for each request kind
  function automatic logic [PC_W-1:0] entry_of(logic [KIND_W-1:0] kind);
    logic [PC_W-1:0] e;
    unique case (kind)
      KIND_INIT:   e = PC_INIT0;
      KIND_CMD:    e = PC_CMD;
      KIND_CHAR:   e = PC_CHR;
      KIND_CURSOR: e = PC_CUR;
      KIND_NUMBER: e = PC_NUM_MUL;
      KIND_STORE:  e = PC_GLY_CMD;
      KIND_SHOW:   e = PC_SHOW_CHK;
      default:     e = PC_IDLE;
    endcase
    entry_of = e;
  endfunction

endpackage

// ----- rtl/core/char_lcd_command_sequencer.sv -----
// Top level of the character-LCD command sequencer: configuration registers,
// microcode sequencer and datapath. Depends on clcd_pkg, clcd_seq, clcd_dp.
//
//   channel  signals                                  role
//   in       in_valid / in_ready, request fields      one request per item
//   out      out_valid / out_ready, bus write fields  one bus write per item
//   cfg      cfg_write, cfg_index, cfg_data           register write, no wait
//
// One request at a time, with a dispatch step before each. Init writes its
// set-up bytes; command, char, cursor and show glyph write one byte (show
// checks its index first); store glyph writes the CGRAM address, the rows
// and a DDRAM address; a number takes two steps per digit through the shared
// divide-by-ten multiplier and two per digit through the digit memory read
// port. Each emit step holds while the output register is full and not taken.
// Reset clears the step counter, output valid and counter; loads cfg defaults.
`timescale 1ns / 1ps

module char_lcd_command_sequencer import clcd_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    kind,
  input  logic [BYTE_W-1:0]    byte_value,
  input  logic [COL_W-1:0]     column,
  input  logic                 line,
  input  logic [NUM_W-1:0]     number,
  input  logic [BYTE_W-1:0]    glyph_index,
  input  logic [ROWS_W-1:0]    glyph_rows,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 register_select,
  output logic [BYTE_W-1:0]    bus_byte,
  output logic [MS_W-1:0]      pulse_ms,
  output logic [MS_W-1:0]      wait_before_ms,
  output logic [WAIT_W-1:0]    wait_after_ms,
  output logic                 last
);

  cfg_t     cfg;
  seq_ctl_t ctl;
  dp_stat_t stat;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strobe_ms    <= 8'd1;
      cfg.hold_ms      <= 8'd1;
      cfg.powerup_ms   <= 8'd50;
      cfg.init_gap_ms  <= 8'd1;
      cfg.clear_gap_ms <= 8'd3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STROBE:    cfg.strobe_ms    <= cfg_data;
        REG_HOLD:      cfg.hold_ms      <= cfg_data;
        REG_POWERUP:   cfg.powerup_ms   <= cfg_data;
        REG_INIT_GAP:  cfg.init_gap_ms  <= cfg_data;
        REG_CLEAR_GAP: cfg.clear_gap_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  clcd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .stat     (stat),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  clcd_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .cfg             (cfg),
    .byte_value      (byte_value),
    .column          (column),
    .line            (line),
    .number          (number),
    .glyph_index     (glyph_index),
    .glyph_rows      (glyph_rows),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .register_select (register_select),
    .bus_byte        (bus_byte),
    .pulse_ms        (pulse_ms),
    .wait_before_ms  (wait_before_ms),
    .wait_after_ms   (wait_after_ms),
    .last            (last)
  );

endmodule

// ----- rtl/core/clcd_seq.sv -----
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on clcd_pkg.
`timescale 1ns / 1ps

module clcd_seq import clcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] kind,
  input  dp_stat_t          stat,
  output logic              in_ready,
  output seq_ctl_t          ctl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          uw;
  logic            go;
  logic            cond_hit;

  // Fetch the control word of this step
  assign uw = ucode(pc);

  // Hold on dispatch without an item, and on emit while the output is full and not taken
  always_comb begin
    unique case (uw.op)
      OP_DISPATCH: go = in_valid;
      OP_EMIT:     go = stat.slot_free;
      default:     go = 1'b1;
    endcase
  end

  // Select the jump condition
  always_comb begin
    unique case (uw.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_DIV_MORE:  cond_hit = stat.div_more;
      C_CNT_NZ:    cond_hit = stat.cnt_nz;
      C_ROW_MORE:  cond_hit = stat.row_more;
      C_GLYPH_BAD: cond_hit = stat.glyph_bad;
      default:     cond_hit = 1'b0;
    endcase
  end

  // Advance the step counter
  always_comb begin
    priority if (!go) begin
      pc_next = pc;
    end else if (uw.op == OP_DISPATCH) begin
      pc_next = entry_of(kind);
    end else if (cond_hit) begin
      pc_next = uw.target;
    end else if (uw.fin) begin
      pc_next = PC_IDLE;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign in_ready = (uw.op == OP_DISPATCH);
  assign ctl.take = go && (uw.op == OP_DISPATCH);
  assign ctl.go   = go;
  assign ctl.uw   = uw;

endmodule

// ----- rtl/core/clcd_dp.sv -----
// Datapath: item registers, divide-by-ten unit, digit memory and output register.
// Depends on clcd_pkg; driven by clcd_seq.
`timescale 1ns / 1ps

module clcd_dp import clcd_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  seq_ctl_t          ctl,
  input  cfg_t              cfg,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic [COL_W-1:0]  column,
  input  logic              line,
  input  logic [NUM_W-1:0]  number,
  input  logic [BYTE_W-1:0] glyph_index,
  input  logic [ROWS_W-1:0] glyph_rows,
  output dp_stat_t          stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              register_select,
  output logic [BYTE_W-1:0] bus_byte,
  output logic [MS_W-1:0]   pulse_ms,
  output logic [MS_W-1:0]   wait_before_ms,
  output logic [WAIT_W-1:0] wait_after_ms,
  output logic              last
);

  localparam int CNT_MAX = (MAX_DIGITS > GLYPH_ROWS) ? MAX_DIGITS : GLYPH_ROWS;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int IDX_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  // Item registers
  logic [BYTE_W-1:0] byte_r;
  logic [COL_W-1:0]  column_r;
  logic              line_r;
  logic [NUM_W-1:0]  num_r;
  logic [BYTE_W-1:0] gidx_r;
  logic [ROWS_W-1:0] rows_r;

  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_dec;
  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     quot;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] q_times10;
  logic [DIGIT_W-1:0] dmem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_q;

  logic do_mul, do_fix, do_rd, do_emit;
  logic [BYTE_W-1:0] byte_sel;
  logic              last_sel;
  logic [MS_W-1:0]   gap_sel;

  assign do_mul  = ctl.go && (ctl.uw.op == OP_MUL);
  assign do_fix  = ctl.go && (ctl.uw.op == OP_FIX);
  assign do_rd   = ctl.go && (ctl.uw.op == OP_RD);
  assign do_emit = ctl.go && (ctl.uw.op == OP_EMIT);

  // Capture the item on dispatch
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      byte_r   <= byte_value;
      column_r <= column;
      line_r   <= line;
      gidx_r   <= glyph_index;
      rows_r   <= glyph_rows;
    end
  end

  // Quotient and remainder of the registered product; the remainder needs only
  // the low four bits since it is known to be below ten
  assign quot      = prod[PROD_W-1:DIV_SHIFT];
  assign q_times10 = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign rem       = num_r[DIGIT_W-1:0] - q_times10;
  assign cnt_dec   = cnt - 1'b1;

  // Multiply step, then fix-up step that writes the digit and shrinks the number
  always_ff @(posedge clk) begin
    if (do_mul) begin
      prod <= num_r * RECIP;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      num_r <= number;
    end else if (do_fix) begin
      num_r <= {{(NUM_W - Q_W){1'b0}}, quot};
    end
  end

  // Digit and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.take) begin
      cnt <= '0;
    end else if (do_fix || (do_emit && ctl.uw.cnt_up)) begin
      cnt <= cnt + 1'b1;
    end else if (do_rd) begin
      cnt <= cnt_dec;
    end
  end

  // Digit memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (do_fix) begin
      dmem[cnt[IDX_W-1:0]] <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (do_rd) begin
      rd_q <= dmem[cnt_dec[IDX_W-1:0]];
    end
  end

  // Status for the sequencer jumps
  assign stat.div_more  = (quot != '0) && (cnt < CNT_W'(MAX_DIGITS - 1));
  assign stat.cnt_nz    = (cnt != '0);
  assign stat.row_more  = (cnt != CNT_W'(GLYPH_ROWS - 1));
  assign stat.glyph_bad = |gidx_r[BYTE_W-1:3];
  assign stat.slot_free = !out_valid || out_ready;

  // Byte source
  always_comb begin
    unique case (ctl.uw.src)
      S_IMM:    byte_sel = ctl.uw.imm;
      S_BYTE:   byte_sel = byte_r;
      S_CURSOR: byte_sel = LCD_DDRAM + {2'b00, column_r} + {1'b0, line_r, 6'b000000};
      S_DIGIT:  byte_sel = ASCII_ZERO + {4'b0000, rd_q};
      S_GADDR:  byte_sel = LCD_CGRAM + {gidx_r[4:0], 3'b000};
      S_ROW:    byte_sel = rows_r[{cnt[ROW_SEL_W-1:0], 3'b000} +: BYTE_W];
      S_GIDX:   byte_sel = gidx_r;
      default:  byte_sel = ctl.uw.imm;
    endcase
  end

  // Wait-after gap
  always_comb begin
    unique case (ctl.uw.wa)
      A_INIT:  gap_sel = cfg.init_gap_ms;
      A_CLEAR: gap_sel = cfg.clear_gap_ms;
      default: gap_sel = '0;
    endcase
  end

  // Last-write flag
  always_comb begin
    unique case (ctl.uw.lst)
      L_YES:      last_sel = 1'b1;
      L_CNT_ZERO: last_sel = (cnt == '0);
      default:    last_sel = 1'b0;
    endcase
  end

  // Output register: load on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      register_select <= ctl.uw.rs;
      bus_byte        <= byte_sel;
      pulse_ms        <= cfg.strobe_ms;
      wait_before_ms  <= (ctl.uw.wb == W_POWERUP) ? cfg.powerup_ms : '0;
      wait_after_ms   <= {1'b0, cfg.hold_ms} + {1'b0, gap_sel};
      last            <= last_sel;
    end
  end

endmodule

// ----- rtl/core/clcd_checker.sv -----
// Port-level checks of the LCD command sequencer, bound to the top level.
// Depends on clcd_pkg and char_lcd_command_sequencer_defines.svh.
`timescale 1ns / 1ps
`include "char_lcd_command_sequencer_defines.svh"

module clcd_checker import clcd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [KIND_W-1:0] kind,
  input logic              out_valid,
  input logic              out_ready,
  input logic              register_select,
  input logic [BYTE_W-1:0] bus_byte,
  input logic [MS_W-1:0]   wait_before_ms,
  input logic              last
);

  // Output is empty right after reset
  `CLCD_ASSERT(a_rst_empty, rst |=> !out_valid, "output valid after reset")

  // A stalled write keeps its byte and flag
  `CLCD_ASSERT_RUN(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(bus_byte) && $stable(last),
    "stalled write changed")

  // An init request keeps the block busy for its writes
  `CLCD_ASSERT_RUN(a_init_busy,
    in_valid && in_ready && kind == KIND_INIT |=> !in_ready,
    "ready right after init item")

  // Only the function-set write of init carries a power-up wait
  `CLCD_ASSERT_RUN(a_wait_before,
    out_valid && wait_before_ms != 8'd0 |-> !register_select && bus_byte == LCD_FUNC_SET && !last,
    "wait before on wrong write")

endmodule

bind char_lcd_command_sequencer clcd_checker u_clcd_checker (.*);
